// ===== src/dlr_pkg.sv =====
// Shared types and constants for the DDA line rasterizer.
package dlr_pkg;

	localparam int CFG_W    = 12;
	localparam int ADDR_W   = 22;
	localparam int COLOR_W  = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

	typedef struct packed {
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
	} canvas_t;

endpackage

// ===== src/dlr_front.sv =====
// Front end: accepts items, runs line setup (steps and increments) and queues commands.
module dlr_front #(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [COORD_BITS-1:0]             x_start,
	input  logic [COORD_BITS-1:0]             y_start,
	input  logic [COORD_BITS-1:0]             x_end,
	input  logic [COORD_BITS-1:0]             y_end,
	input  logic [dlr_pkg::COLOR_W-1:0]       line_color,
	input  logic                              q_full,
	output logic                              push,
	output logic [1+2*COORD_BITS+2*(FRAC_BITS+2)+COORD_BITS+dlr_pkg::COLOR_W-1:0] push_data
);

	localparam int MAG_W = COORD_BITS;
	localparam int REM_W = MAG_W + 1;
	localparam int Q_W   = FRAC_BITS + 1;
	localparam int INC_W = FRAC_BITS + 2;
	localparam int CNT_W = $clog2(Q_W);
	localparam int ENT_W = 1 + 2*COORD_BITS + 2*INC_W + MAG_W + dlr_pkg::COLOR_W;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t state_q;
	logic [CNT_W-1:0] cnt_q;

	logic [COORD_BITS-1:0]       xs_q, ys_q;
	logic [dlr_pkg::COLOR_W-1:0] color_q;
	logic [MAG_W-1:0]            steps_q;
	logic                        neg_x_q, neg_y_q;
	logic [REM_W-1:0]            rem_x_q, rem_y_q;
	logic [Q_W-1:0]              quo_x_q, quo_y_q;

	logic                  acc;
	logic [COORD_BITS:0]   dx_d, dy_d, ndx_d, ndy_d;
	logic [MAG_W-1:0]      abs_x, abs_y, steps_d;
	logic                  ge_x, ge_y;
	logic [REM_W-1:0]      r1_x, r1_y, div_s;
	logic [INC_W-1:0]      qx_ext, qy_ext, inc_x, inc_y;

	assign in_ready = (state_q == F_IDLE) && !q_full;
	assign acc      = in_valid && in_ready;

	assign dx_d  = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
	assign dy_d  = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
	assign ndx_d = -dx_d;
	assign ndy_d = -dy_d;
	assign abs_x = dx_d[COORD_BITS] ? ndx_d[MAG_W-1:0] : dx_d[MAG_W-1:0];
	assign abs_y = dy_d[COORD_BITS] ? ndy_d[MAG_W-1:0] : dy_d[MAG_W-1:0];
	assign steps_d = (abs_x > abs_y) ? abs_x : abs_y;

	// one restoring-division step per cycle on each axis
	assign div_s = {1'b0, steps_q};
	assign ge_x  = rem_x_q >= div_s;
	assign ge_y  = rem_y_q >= div_s;
	assign r1_x  = ge_x ? rem_x_q - div_s : rem_x_q;
	assign r1_y  = ge_y ? rem_y_q - div_s : rem_y_q;

	assign qx_ext = {1'b0, quo_x_q};
	assign qy_ext = {1'b0, quo_y_q};
	assign inc_x  = neg_x_q ? -qx_ext : qx_ext;
	assign inc_y  = neg_y_q ? -qy_ext : qy_ext;

	assign push = (acc && kind == dlr_pkg::KIND_TICK) || (state_q == F_PUSH && !q_full);

	always_comb begin
		if (state_q == F_PUSH) begin
			push_data = {dlr_pkg::KIND_START, xs_q, ys_q, inc_x, inc_y, steps_q, color_q};
		end else begin
			push_data = {dlr_pkg::KIND_TICK, {(ENT_W-1){1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (acc && kind == dlr_pkg::KIND_START) begin
						state_q <= F_DIV;
						cnt_q   <= CNT_W'(Q_W - 1);
					end
				end
				F_DIV: begin
					if (cnt_q == '0) begin
						state_q <= F_PUSH;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && kind == dlr_pkg::KIND_START) begin
			xs_q    <= x_start;
			ys_q    <= y_start;
			color_q <= line_color;
			steps_q <= steps_d;
			neg_x_q <= dx_d[COORD_BITS];
			neg_y_q <= dy_d[COORD_BITS];
			rem_x_q <= {1'b0, abs_x};
			rem_y_q <= {1'b0, abs_y};
			quo_x_q <= '0;
			quo_y_q <= '0;
		end else if (state_q == F_DIV) begin
			rem_x_q <= {r1_x[MAG_W-1:0], 1'b0};
			rem_y_q <= {r1_y[MAG_W-1:0], 1'b0};
			quo_x_q <= {quo_x_q[Q_W-2:0], ge_x};
			quo_y_q <= {quo_y_q[Q_W-2:0], ge_y};
		end
	end

endmodule

// ===== src/dlr_queue.sv =====
// Small first-word-fall-through command queue between front and back.
module dlr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic             full,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== src/dlr_back.sv =====
// Back end: holds the active line, steps the position and emits clipped pixels.
module dlr_back #(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dlr_pkg::canvas_t                  canvas,
	input  logic                              q_valid,
	input  logic [1+2*COORD_BITS+2*(FRAC_BITS+2)+COORD_BITS+dlr_pkg::COLOR_W-1:0] q_data,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              inside_res,
	output logic [COORD_BITS-1:0]             pixel_x,
	output logic [COORD_BITS-1:0]             pixel_y,
	output logic [dlr_pkg::ADDR_W-1:0]        address,
	output logic [dlr_pkg::COLOR_W-1:0]       write_color,
	output logic                              last
);

	localparam int MAG_W  = COORD_BITS;
	localparam int INC_W  = FRAC_BITS + 2;
	localparam int POS_W  = COORD_BITS + FRAC_BITS + 2;
	localparam int IP_W   = POS_W - FRAC_BITS;
	localparam int CMP_W  = ((COORD_BITS > dlr_pkg::CFG_W) ? COORD_BITS : dlr_pkg::CFG_W) + 1;
	localparam int PROD_R = COORD_BITS + dlr_pkg::CFG_W + 1;
	localparam int PROD_W = (PROD_R > dlr_pkg::ADDR_W) ? PROD_R : dlr_pkg::ADDR_W;

	logic                        e_kind;
	logic [COORD_BITS-1:0]       e_xs, e_ys;
	logic [INC_W-1:0]            e_inc_x, e_inc_y;
	logic [MAG_W-1:0]            e_steps;
	logic [dlr_pkg::COLOR_W-1:0] e_color;

	logic [POS_W-1:0]            pos_x_q, pos_y_q;
	logic [INC_W-1:0]            inc_x_q, inc_y_q;
	logic [MAG_W-1:0]            steps_q;
	logic [dlr_pkg::COLOR_W-1:0] color_q;

	logic                        valid_s1;
	logic [COORD_BITS-1:0]       px_s1, py_s1;
	logic                        inside_s1, last_s1;
	logic [dlr_pkg::COLOR_W-1:0] color_s1;

	logic                        valid_s2, inside_s2, last_s2;
	logic [COORD_BITS-1:0]       px_s2, py_s2;
	logic [dlr_pkg::ADDR_W-1:0]  addr_s2;
	logic [dlr_pkg::COLOR_W-1:0] color_s2;

	logic             en_s1, en_s2, active, fire, is_start;
	logic             rnd_x, rnd_y;
	logic [IP_W-1:0]  ip_x, ip_y;
	logic [COORD_BITS-1:0] px_d, py_d;
	logic             inside_d;
	logic [PROD_W-1:0] addr_full;

	assign {e_kind, e_xs, e_ys, e_inc_x, e_inc_y, e_steps, e_color} = q_data;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign pop      = q_valid && en_s1;
	assign active   = steps_q != '0;
	assign is_start = pop && e_kind == dlr_pkg::KIND_START;
	assign fire     = pop && e_kind == dlr_pkg::KIND_TICK && active;

	// truncate toward zero: floor, plus one for a negative value with a fraction
	assign rnd_x = pos_x_q[POS_W-1] && (|pos_x_q[FRAC_BITS-1:0]);
	assign rnd_y = pos_y_q[POS_W-1] && (|pos_y_q[FRAC_BITS-1:0]);
	assign ip_x  = pos_x_q[POS_W-1:FRAC_BITS] + IP_W'(rnd_x);
	assign ip_y  = pos_y_q[POS_W-1:FRAC_BITS] + IP_W'(rnd_y);
	assign px_d  = ip_x[COORD_BITS-1:0];
	assign py_d  = ip_y[COORD_BITS-1:0];

	assign inside_d = !px_d[COORD_BITS-1] && !py_d[COORD_BITS-1]
		&& (CMP_W'(px_d) < CMP_W'(canvas.width))
		&& (CMP_W'(py_d) < CMP_W'(canvas.height));

	assign addr_full = PROD_W'(py_s1) * PROD_W'(canvas.width) + PROD_W'(px_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (is_start) begin
				steps_q <= e_steps;
			end else if (fire) begin
				steps_q <= steps_q - 1'b1;
			end
			if (en_s1) begin
				valid_s1 <= fire;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_start) begin
			pos_x_q <= {{(POS_W-COORD_BITS-FRAC_BITS){e_xs[COORD_BITS-1]}}, e_xs,
				{FRAC_BITS{1'b0}}};
			pos_y_q <= {{(POS_W-COORD_BITS-FRAC_BITS){e_ys[COORD_BITS-1]}}, e_ys,
				{FRAC_BITS{1'b0}}};
			inc_x_q <= e_inc_x;
			inc_y_q <= e_inc_y;
			color_q <= e_color;
		end else if (fire) begin
			pos_x_q <= pos_x_q + {{(POS_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
			pos_y_q <= pos_y_q + {{(POS_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q};
		end
		if (fire) begin
			px_s1     <= px_d;
			py_s1     <= py_d;
			inside_s1 <= inside_d;
			last_s1   <= steps_q == MAG_W'(1);
			color_s1  <= color_q;
		end
		if (en_s2 && valid_s1) begin
			px_s2     <= px_s1;
			py_s2     <= py_s1;
			inside_s2 <= inside_s1;
			last_s2   <= last_s1;
			color_s2  <= color_s1;
			addr_s2   <= inside_s1 ? addr_full[dlr_pkg::ADDR_W-1:0] : '0;
		end
	end

	assign out_valid   = valid_s2;
	assign inside_res  = inside_s2;
	assign pixel_x     = px_s2;
	assign pixel_y     = py_s2;
	assign address     = addr_s2;
	assign write_color = color_s2;
	assign last        = last_s2;

endmodule

// ===== src/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: canvas registers, front end, queue, back end.
//
// Input channel (in_valid/in_ready): kind 0 starts a line from the two endpoints
// and color; kind 1 is a tick that emits the next pixel of the active line.
// Output channel (out_valid/out_ready): one beat per productive tick, carrying
// position, clip flag, linear address, color and a last flag.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 canvas width,
// index 1 canvas height; always ready. The user must ensure it is written only while
// the block is idle; the block does not enforce this. Throughput: ticks move at one
// per cycle while the queue has room. A start beat holds the front end, which takes
// no new item while the increment divider resolves one quotient bit per cycle and
// the setup is queued. A tick passes register s1, then s2, to the output.
// Reset: canvas is 640 x 480, no line is active, the command queue is empty.
// When the receiver stalls the output beat holds, the back end stops, the
// 4-entry queue fills and in_ready drops.
module dda_line_rasterizer #(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dlr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dlr_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic [COORD_BITS-1:0]               x_start,
	input  logic [COORD_BITS-1:0]               y_start,
	input  logic [COORD_BITS-1:0]               x_end,
	input  logic [COORD_BITS-1:0]               y_end,
	input  logic [dlr_pkg::COLOR_W-1:0]         line_color,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                inside_res,
	output logic [COORD_BITS-1:0]               pixel_x,
	output logic [COORD_BITS-1:0]               pixel_y,
	output logic [dlr_pkg::ADDR_W-1:0]          address,
	output logic [dlr_pkg::COLOR_W-1:0]         write_color,
	output logic                                last
);

	localparam int ENT_W = 1 + 2*COORD_BITS + 2*(FRAC_BITS+2) + COORD_BITS + dlr_pkg::COLOR_W;
	localparam int Q_DEPTH = 4;

	dlr_pkg::canvas_t canvas_q;

	logic             push, q_full, q_valid, pop;
	logic [ENT_W-1:0] push_data, q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_q.width  <= dlr_pkg::WIDTH_RESET;
			canvas_q.height <= dlr_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				dlr_pkg::CFG_IDX_WIDTH:  canvas_q.width  <= cfg_data;
				dlr_pkg::CFG_IDX_HEIGHT: canvas_q.height <= cfg_data;
				default: ;
			endcase
		end
	end

	dlr_front #(
		.FRAC_BITS  (FRAC_BITS),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.line_color (line_color),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	dlr_queue #(
		.WIDTH (ENT_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (push_data),
		.pop      (pop),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_data  (q_data)
	);

	dlr_back #(
		.FRAC_BITS  (FRAC_BITS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.canvas      (canvas_q),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.inside_res  (inside_res),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.address     (address),
		.write_color (write_color),
		.last        (last)
	);

endmodule
